@@ src/text_edge_list_to_adjacency_defines.svh @@
// ----------------------------------------------------------------------------
// text_edge_list_to_adjacency_defines.svh
// Assertion macros shared by the edge-list adjacency builder.
// ----------------------------------------------------------------------------
`ifndef TEXT_EDGE_LIST_TO_ADJACENCY_DEFINES_SVH
`define TEXT_EDGE_LIST_TO_ADJACENCY_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define TELA_CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle
`define TELA_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tela_pkg.sv @@
// ----------------------------------------------------------------------------
// tela_pkg
// Shared types and constants of the edge-list adjacency builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tela_pkg;

  // Default sizes of the graph stores
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_EDGES_DEF    = 1024;

  // Fixed field widths of the ports
  localparam int VERT_W   = 11;
  localparam int SLOT_W   = 11;
  localparam int DEG_W    = 12;
  localparam int BYTE_W   = 8;

  // Number accumulator saturates at this value
  localparam int ACC_W = 18;
  localparam logic [ACC_W-1:0] NUM_CAP = 18'h20000;
  localparam logic [VERT_W-1:0] FIELD_MAX = 11'h7FF;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam int RADIX = 10;

  // Commands
  localparam logic CMD_TEXT  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_OK    = 2'd1,
    ST_BAD   = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Parser phases
  typedef enum logic [8:0] {
    PH_LEAD = 9'b000000001,
    PH_VCT  = 9'b000000010,
    PH_GAP1 = 9'b000000100,
    PH_ECT  = 9'b000001000,
    PH_GAP2 = 9'b000010000,
    PH_A    = 9'b000100000,
    PH_GAP3 = 9'b001000000,
    PH_B    = 9'b010000000,
    PH_GAP4 = 9'b100000000
  } phase_t;

  // Build and query sequencer states
  typedef enum logic [17:0] {
    S_IDLE   = 18'b000000000000000001,
    S_CLR    = 18'b000000000000000010,
    S_CNT_RD = 18'b000000000000000100,
    S_CNT_A  = 18'b000000000000001000,
    S_CNT_AW = 18'b000000000000010000,
    S_CNT_B  = 18'b000000000000100000,
    S_CNT_BW = 18'b000000000001000000,
    S_PFX_RD = 18'b000000000010000000,
    S_PFX_WR = 18'b000000000100000000,
    S_SC_RD  = 18'b000000001000000000,
    S_SC_A   = 18'b000000010000000000,
    S_SC_AW  = 18'b000000100000000000,
    S_SC_B   = 18'b000001000000000000,
    S_SC_BW  = 18'b000010000000000000,
    S_FIN    = 18'b000100000000000000,
    S_Q_RD   = 18'b001000000000000000,
    S_Q_NB   = 18'b010000000000000000,
    S_Q_OUT  = 18'b100000000000000000
  } seq_state_t;

  // Parser to sequencer control
  typedef struct packed {
    logic wr_first;
    logic wr_second;
    logic build;
    logic bad;
  } parse_ctl_t;

  // Sequencer status to top level
  typedef struct packed {
    logic busy;
    logic done;
    logic query;
    logic hit;
  } seq_stat_t;

endpackage

@@ src/tela_ram.sv @@
// ----------------------------------------------------------------------------
// tela_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tela_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/tela_parse.sv @@
// ----------------------------------------------------------------------------
// tela_parse
// Text parser: tracks the phase, accumulates numbers, checks counts and ranges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tela_parse #(
  parameter int MAX_VERTICES = tela_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = tela_pkg::MAX_EDGES_DEF,
  localparam int VW  = $clog2(MAX_VERTICES),
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int ECW = $clog2(MAX_EDGES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  input  logic [tela_pkg::BYTE_W-1:0]   text_byte,
  input  logic                          last_byte,
  output tela_pkg::parse_ctl_t          ctl,
  output logic [EAW-1:0]                ep_idx,
  output logic [VW-1:0]                 ep_val,
  output logic [ECW-1:0]                build_edges,
  output logic [tela_pkg::ACC_W-1:0]    declared_vertices,
  output logic [tela_pkg::ACC_W-1:0]    declared_edges
);

  localparam int PW = tela_pkg::ACC_W + 4;

  tela_pkg::phase_t            phase, phase_next;
  logic [tela_pkg::ACC_W-1:0]  acc, acc_next;
  logic [tela_pkg::ACC_W-1:0]  dv_next, de_next;
  logic [ECW-1:0]              edges, edges_next;
  logic                        failed, failed_next;
  logic                        digit, blank, ep_ok, ok;
  logic [PW-1:0]               prod;

  assign digit = (text_byte >= tela_pkg::CH_ZERO) && (text_byte <= tela_pkg::CH_NINE);
  assign blank = (text_byte <= tela_pkg::CH_SPACE);
  assign ep_ok = (acc != '0) && (acc <= declared_vertices);
  assign prod  = (PW'(acc) << 3) + (PW'(acc) << 1) + PW'(text_byte - tela_pkg::CH_ZERO);
  assign ep_idx = EAW'(edges);
  assign ep_val = VW'(acc - tela_pkg::ACC_W'(1));

  // Work out the next parse state for one text word
  always_comb begin
    phase_next  = phase;
    acc_next    = acc;
    dv_next     = declared_vertices;
    de_next     = declared_edges;
    edges_next  = edges;
    failed_next = failed;
    ctl         = '0;
    ok          = 1'b0;
    if (byte_valid) begin
      if (digit) begin
        unique case (phase)
          tela_pkg::PH_LEAD: phase_next = tela_pkg::PH_VCT;
          tela_pkg::PH_GAP1: phase_next = tela_pkg::PH_ECT;
          tela_pkg::PH_GAP2,
          tela_pkg::PH_GAP4: phase_next = tela_pkg::PH_A;
          tela_pkg::PH_GAP3: phase_next = tela_pkg::PH_B;
          default: phase_next = phase;
        endcase
        acc_next = (prod > PW'(tela_pkg::NUM_CAP)) ? tela_pkg::NUM_CAP
                                                   : tela_pkg::ACC_W'(prod);
      end else if (blank) begin
        acc_next = '0;
        unique case (phase)
          tela_pkg::PH_VCT: begin
            dv_next = acc;
            if (32'(acc) > MAX_VERTICES) failed_next = 1'b1;
            phase_next = tela_pkg::PH_GAP1;
          end
          tela_pkg::PH_ECT: begin
            de_next = acc;
            if (32'(acc) > MAX_EDGES) failed_next = 1'b1;
            phase_next = tela_pkg::PH_GAP2;
          end
          tela_pkg::PH_A: begin
            if (!ep_ok) failed_next = 1'b1;
            ctl.wr_first = (32'(edges) < MAX_EDGES);
            phase_next = tela_pkg::PH_GAP3;
          end
          tela_pkg::PH_B: begin
            if (!ep_ok) failed_next = 1'b1;
            if ((tela_pkg::ACC_W'(edges) >= declared_edges) || (32'(edges) >= MAX_EDGES)) begin
              failed_next = 1'b1;
            end else begin
              ctl.wr_second = 1'b1;
              edges_next = edges + ECW'(1);
            end
            phase_next = tela_pkg::PH_GAP4;
          end
          default: phase_next = phase;
        endcase
      end else begin
        failed_next = 1'b1;
      end
      if (last_byte) begin
        ok = !failed_next && !digit && (phase_next == tela_pkg::PH_GAP4) &&
             (tela_pkg::ACC_W'(edges_next) == de_next);
        ctl.build   = ok;
        ctl.bad     = !ok;
        phase_next  = tela_pkg::PH_LEAD;
        acc_next    = '0;
        edges_next  = '0;
        failed_next = 1'b0;
      end
    end
  end

  assign build_edges = (ok) ? ((ctl.wr_second) ? edges + ECW'(1) : edges) : edges;

  // Hold parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= tela_pkg::PH_LEAD;
      acc               <= '0;
      declared_vertices <= '0;
      declared_edges    <= '0;
      edges             <= '0;
      failed            <= 1'b0;
    end else begin
      phase             <= phase_next;
      acc               <= acc_next;
      declared_vertices <= dv_next;
      declared_edges    <= de_next;
      edges             <= edges_next;
      failed            <= failed_next;
    end
  end

endmodule

@@ src/tela_build.sv @@
// ----------------------------------------------------------------------------
// tela_build
// Memory sequencer: stores endpoints, counts degrees, lays out and fills the
// neighbour lists, and answers adjacency queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tela_build #(
  parameter int MAX_VERTICES = tela_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = tela_pkg::MAX_EDGES_DEF,
  localparam int VW  = $clog2(MAX_VERTICES),
  localparam int VCW = $clog2(MAX_VERTICES + 1),
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int ECW = $clog2(MAX_EDGES + 1),
  localparam int DGW = $clog2(2 * MAX_EDGES + 1),
  localparam int NAW = $clog2(2 * MAX_EDGES)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tela_pkg::parse_ctl_t        ctl,
  input  logic [EAW-1:0]              ep_idx,
  input  logic [VW-1:0]               ep_val,
  input  logic [VCW-1:0]              vcount,
  input  logic [ECW-1:0]              ecount,
  input  logic                        q_go,
  input  logic [VW-1:0]               q_vi,
  input  logic [tela_pkg::SLOT_W-1:0] q_slot,
  output tela_pkg::seq_stat_t         stat,
  output logic [VW-1:0]               q_neighbor,
  output logic [DGW-1:0]              q_degree
);

  localparam int CW = (VCW > ECW) ? VCW : ECW;

  tela_pkg::seq_state_t        state, state_next;
  logic [CW-1:0]               idx;
  logic [VCW-1:0]              vcnt_r;
  logic [ECW-1:0]              ecnt_r;
  logic [VW-1:0]               a_r, b_r, q_vi_r;
  logic [DGW-1:0]              pos, q_deg_r;
  logic [tela_pkg::SLOT_W-1:0] q_slot_r;
  logic                        q_hit_r;
  logic                        last_v, last_e;

  logic            deg_we, st_we, nbr_we;
  logic [VW-1:0]   deg_waddr, deg_raddr, st_raddr;
  logic [DGW-1:0]  deg_wdata, deg_rdata, st_rdata;
  logic [NAW-1:0]  nbr_waddr, nbr_raddr;
  logic [VW-1:0]   nbr_wdata, nbr_rdata, ea_rdata, eb_rdata;

  assign last_v = ((CW + 1)'(idx) + (CW + 1)'(1)) == (CW + 1)'(vcnt_r);
  assign last_e = ((CW + 1)'(idx) + (CW + 1)'(1)) == (CW + 1)'(ecnt_r);

  // Endpoint stores, written while parsing
  tela_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_first (
    .clk(clk), .we(ctl.wr_first), .waddr(ep_idx), .wdata(ep_val),
    .raddr(EAW'(idx)), .rdata(ea_rdata)
  );
  tela_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_second (
    .clk(clk), .we(ctl.wr_second), .waddr(ep_idx), .wdata(ep_val),
    .raddr(EAW'(idx)), .rdata(eb_rdata)
  );

  // Degree, list start and neighbour stores
  tela_ram #(.WIDTH(DGW), .DEPTH(MAX_VERTICES)) u_degree (
    .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .raddr(deg_raddr), .rdata(deg_rdata)
  );
  tela_ram #(.WIDTH(DGW), .DEPTH(MAX_VERTICES)) u_start (
    .clk(clk), .we(st_we), .waddr(VW'(idx)), .wdata(pos),
    .raddr(st_raddr), .rdata(st_rdata)
  );
  tela_ram #(.WIDTH(VW), .DEPTH(2 * MAX_EDGES)) u_nbr (
    .clk(clk), .we(nbr_we), .waddr(nbr_waddr), .wdata(nbr_wdata),
    .raddr(nbr_raddr), .rdata(nbr_rdata)
  );

  // Drive memory ports and choose the next step
  always_comb begin
    state_next = state;
    deg_we     = 1'b0;
    deg_waddr  = VW'(idx);
    deg_wdata  = deg_rdata + DGW'(1);
    deg_raddr  = VW'(idx);
    st_we      = 1'b0;
    st_raddr   = VW'(idx);
    nbr_we     = 1'b0;
    nbr_waddr  = NAW'(st_rdata + deg_rdata);
    nbr_wdata  = b_r;
    nbr_raddr  = NAW'(st_rdata + DGW'(q_slot_r));
    unique case (state)
      tela_pkg::S_IDLE: begin
        if (ctl.build) state_next = tela_pkg::S_CLR;
        else if (q_go) state_next = tela_pkg::S_Q_RD;
      end
      tela_pkg::S_CLR: begin
        deg_we    = 1'b1;
        deg_wdata = '0;
        if (last_v) state_next = tela_pkg::S_CNT_RD;
      end
      tela_pkg::S_CNT_RD: state_next = tela_pkg::S_CNT_A;
      tela_pkg::S_CNT_A: begin
        deg_raddr  = ea_rdata;
        state_next = tela_pkg::S_CNT_AW;
      end
      tela_pkg::S_CNT_AW: begin
        deg_we     = 1'b1;
        deg_waddr  = a_r;
        state_next = tela_pkg::S_CNT_B;
      end
      tela_pkg::S_CNT_B: begin
        deg_raddr  = b_r;
        state_next = tela_pkg::S_CNT_BW;
      end
      tela_pkg::S_CNT_BW: begin
        deg_we     = 1'b1;
        deg_waddr  = b_r;
        state_next = last_e ? tela_pkg::S_PFX_RD : tela_pkg::S_CNT_RD;
      end
      tela_pkg::S_PFX_RD: state_next = tela_pkg::S_PFX_WR;
      tela_pkg::S_PFX_WR: begin
        st_we      = 1'b1;
        deg_we     = 1'b1;
        deg_wdata  = '0;
        state_next = last_v ? tela_pkg::S_SC_RD : tela_pkg::S_PFX_RD;
      end
      tela_pkg::S_SC_RD: state_next = tela_pkg::S_SC_A;
      tela_pkg::S_SC_A: begin
        deg_raddr  = ea_rdata;
        st_raddr   = ea_rdata;
        state_next = tela_pkg::S_SC_AW;
      end
      tela_pkg::S_SC_AW: begin
        nbr_we     = 1'b1;
        deg_we     = 1'b1;
        deg_waddr  = a_r;
        state_next = tela_pkg::S_SC_B;
      end
      tela_pkg::S_SC_B: begin
        deg_raddr  = b_r;
        st_raddr   = b_r;
        state_next = tela_pkg::S_SC_BW;
      end
      tela_pkg::S_SC_BW: begin
        nbr_we     = 1'b1;
        nbr_wdata  = a_r;
        deg_we     = 1'b1;
        deg_waddr  = b_r;
        state_next = last_e ? tela_pkg::S_FIN : tela_pkg::S_SC_RD;
      end
      tela_pkg::S_FIN: state_next = tela_pkg::S_IDLE;
      tela_pkg::S_Q_RD: begin
        deg_raddr  = q_vi_r;
        st_raddr   = q_vi_r;
        state_next = tela_pkg::S_Q_NB;
      end
      tela_pkg::S_Q_NB: state_next = tela_pkg::S_Q_OUT;
      tela_pkg::S_Q_OUT: state_next = tela_pkg::S_IDLE;
      default: state_next = tela_pkg::S_IDLE;
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tela_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold counters, latched endpoints and query data
  always_ff @(posedge clk) begin
    unique case (state)
      tela_pkg::S_IDLE: begin
        idx      <= '0;
        pos      <= '0;
        vcnt_r   <= vcount;
        ecnt_r   <= ecount;
        q_vi_r   <= q_vi;
        q_slot_r <= q_slot;
      end
      tela_pkg::S_CLR: idx <= last_v ? '0 : idx + CW'(1);
      tela_pkg::S_CNT_A, tela_pkg::S_SC_A: begin
        a_r <= ea_rdata;
        b_r <= eb_rdata;
      end
      tela_pkg::S_CNT_BW, tela_pkg::S_SC_BW: idx <= last_e ? '0 : idx + CW'(1);
      tela_pkg::S_PFX_WR: begin
        pos <= pos + deg_rdata;
        idx <= last_v ? '0 : idx + CW'(1);
      end
      tela_pkg::S_Q_NB: begin
        q_deg_r <= deg_rdata;
        q_hit_r <= 32'(q_slot_r) < 32'(deg_rdata);
      end
      default: ;
    endcase
  end

  assign stat.busy  = (state != tela_pkg::S_IDLE);
  assign stat.done  = (state == tela_pkg::S_FIN) || (state == tela_pkg::S_Q_OUT);
  assign stat.query = (state == tela_pkg::S_Q_OUT);
  assign stat.hit   = q_hit_r;
  assign q_neighbor = nbr_rdata;
  assign q_degree   = q_deg_r;

endmodule

@@ src/text_edge_list_to_adjacency.sv @@
// ----------------------------------------------------------------------------
// text_edge_list_to_adjacency
// Builds neighbour lists from a textual edge list and answers adjacency queries.
// ----------------------------------------------------------------------------
// Usage: raise start with a word (command, text_byte, last_byte, vertex,
// slot) while busy is low; the word is taken on that edge. Every word gives
// one result, shown for one cycle with done high; the receiver cannot stall.
// Text word (not last, or last with a bad graph): result in the next cycle,
//   busy stays low, so text streams at one word per cycle.
// Last text word with a good graph: the sequencer clears V degree entries,
//   counts degrees, lays out list starts and scatters both directions, all
//   with busy high; done comes with status ok at the end.
// Query: out of range answers in the next cycle; otherwise the answer passes
//   through the degree, start and neighbour memories.
// Reset clears the parser and sequencer; no memory clearing pass is needed,
// as the degree store is cleared at the start of every build.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_edge_list_to_adjacency_defines.svh"

module text_edge_list_to_adjacency #(
  parameter int MAX_VERTICES = tela_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = tela_pkg::MAX_EDGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command,
  input  logic [tela_pkg::BYTE_W-1:0] text_byte,
  input  logic                        last_byte,
  input  logic [tela_pkg::VERT_W-1:0] vertex,
  input  logic [tela_pkg::SLOT_W-1:0] slot,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [tela_pkg::VERT_W-1:0] vertex_total,
  output logic [tela_pkg::VERT_W-1:0] edge_total,
  output logic [tela_pkg::VERT_W-1:0] neighbor,
  output logic [tela_pkg::DEG_W-1:0]  degree
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int DGW = $clog2(2 * MAX_EDGES + 1);

  tela_pkg::parse_ctl_t       ctl;
  tela_pkg::seq_stat_t        stat;
  logic [EAW-1:0]             ep_idx;
  logic [VW-1:0]              ep_val, q_nbr;
  logic [ECW-1:0]             build_edges;
  logic [DGW-1:0]             q_deg;
  logic [tela_pkg::ACC_W-1:0] dv, de;
  logic                       accept, text_ok, query_ok, q_go;
  logic                       graph_ready;
  logic                       res_valid;
  tela_pkg::status_t          res_status;

  assign accept   = start && !busy;
  assign text_ok  = accept && (command == tela_pkg::CMD_TEXT);
  assign query_ok = graph_ready && (vertex != '0) &&
                    (tela_pkg::ACC_W'(vertex) <= dv);
  assign q_go     = accept && (command == tela_pkg::CMD_QUERY) && query_ok;
  assign busy     = stat.busy;

  tela_parse #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_parse (
    .clk(clk), .rst(rst), .byte_valid(text_ok), .text_byte(text_byte),
    .last_byte(last_byte), .ctl(ctl), .ep_idx(ep_idx), .ep_val(ep_val),
    .build_edges(build_edges), .declared_vertices(dv), .declared_edges(de)
  );

  tela_build #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_build (
    .clk(clk), .rst(rst), .ctl(ctl), .ep_idx(ep_idx), .ep_val(ep_val),
    .vcount(VCW'(dv)), .ecount(build_edges), .q_go(q_go),
    .q_vi(VW'(vertex - tela_pkg::VERT_W'(1))), .q_slot(slot),
    .stat(stat), .q_neighbor(q_nbr), .q_degree(q_deg)
  );

  // Hold readiness and the one-cycle results
  always_ff @(posedge clk) begin
    if (rst) begin
      graph_ready <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (text_ok) graph_ready <= ctl.build;
      res_valid <= accept && !ctl.build && !q_go;
    end
  end

  always_ff @(posedge clk) begin
    if (command == tela_pkg::CMD_QUERY) res_status <= tela_pkg::ST_RANGE;
    else if (ctl.bad) res_status <= tela_pkg::ST_BAD;
    else res_status <= tela_pkg::ST_BYTE;
  end

  // Select the result word
  always_comb begin
    done     = res_valid || stat.done;
    status   = res_status;
    neighbor = '0;
    degree   = '0;
    if (stat.done) begin
      if (stat.query) begin
        degree = tela_pkg::DEG_W'(q_deg);
        if (stat.hit) begin
          status   = tela_pkg::ST_OK;
          neighbor = tela_pkg::VERT_W'({1'b0, q_nbr} + (VW + 1)'(1));
        end else begin
          status = tela_pkg::ST_RANGE;
        end
      end else begin
        status = tela_pkg::ST_OK;
      end
    end
  end

  assign vertex_total = (dv > tela_pkg::ACC_W'(tela_pkg::FIELD_MAX)) ? tela_pkg::FIELD_MAX
                                                                    : tela_pkg::VERT_W'(dv);
  assign edge_total   = (de > tela_pkg::ACC_W'(tela_pkg::FIELD_MAX)) ? tela_pkg::FIELD_MAX
                                                                    : tela_pkg::VERT_W'(de);

  `TELA_CHK_NEXT(a_byte_reply, text_ok && !last_byte, done && (status == tela_pkg::ST_BYTE), "text word without reply")
  `TELA_CHK_SAME(a_busy_cause, busy && !$past(busy), $past(start), "sequencer started without a word")
  `TELA_CHK_SAME(a_range_zero, done && (status == tela_pkg::ST_RANGE), neighbor == '0, "neighbour on rejected query")
  `TELA_CHK_SAME(a_one_reply, res_valid, !stat.done, "two results in one cycle")

endmodule

@@ sim/tb_text_edge_list_to_adjacency.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_edge_list_to_adjacency
// Feeds graph descriptions and adjacency queries to the builder, predicts every
// result word with a behavioural copy of the parser and list builder, and
// checks each strobed result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_text_edge_list_to_adjacency;
  import tela_pkg::*;

  localparam int NV = 1024;
  localparam int NE = 1024;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic             cmd;
    logic [7:0]       byt;
    logic             last;
    logic [10:0]      vtx;
    logic [10:0]      slt;
  } word_t;

  typedef struct {
    status_t     st;
    logic [10:0] vt;
    logic [10:0] et;
    logic [10:0] nb;
    logic [11:0] dg;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        command = CMD_TEXT;
  logic [7:0]  text_byte = '0;
  logic        last_byte = 1'b0;
  logic [10:0] vertex = '0;
  logic [10:0] slot = '0;
  logic        done;
  logic [1:0]  status;
  logic [10:0] vertex_total;
  logic [10:0] edge_total;
  logic [10:0] neighbor;
  logic [11:0] degree;

  word_t   pending_words[$];
  answer_t awaited_answers[$];
  word_t   cur_word;
  int      words_issued = 0;
  int      words_taken = 0;
  int      gap_left = 0;
  int      burst_left = 0;
  int      cycle_count = 0;
  int      fail_count = 0;

  // shadow parser and graph state
  phase_t      sh_phase;
  int unsigned sh_acc, sh_nverts, sh_nedges, sh_seen;
  int unsigned sh_first[NE], sh_second[NE];
  int unsigned sh_deg[NV], sh_start[NV];
  int unsigned sh_nbr[2*NE];
  bit          sh_failed, sh_ready;

  text_edge_list_to_adjacency DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .text_byte(text_byte), .last_byte(last_byte), .vertex(vertex), .slot(slot),
    .done(done), .status(status), .vertex_total(vertex_total),
    .edge_total(edge_total), .neighbor(neighbor), .degree(degree)
  );

  always #5 clk = ~clk;

  function bit endpoint_valid(int unsigned v);
    return v != 0 && v <= sh_nverts;
  endfunction

  // File a finished number according to the parser phase
  function void file_number();
    int unsigned n;
    n = sh_acc;
    sh_acc = 0;
    case (sh_phase)
      PH_VCT: begin
        sh_nverts = n;
        if (n > NV) sh_failed = 1;
        sh_phase = PH_GAP1;
      end
      PH_ECT: begin
        sh_nedges = n;
        if (n > NE) sh_failed = 1;
        sh_phase = PH_GAP2;
      end
      PH_A: begin
        if (!endpoint_valid(n)) sh_failed = 1;
        if (sh_seen < NE) sh_first[sh_seen] = n;
        sh_phase = PH_GAP3;
      end
      PH_B: begin
        if (!endpoint_valid(n)) sh_failed = 1;
        if (sh_seen >= sh_nedges || sh_seen >= NE) begin
          sh_failed = 1;
        end else begin
          sh_second[sh_seen] = n;
          sh_seen++;
        end
        sh_phase = PH_GAP4;
      end
      default: ;
    endcase
  endfunction

  // Count degrees, lay out list starts and scatter both directions
  function void build_lists();
    int unsigned pos, a, b;
    pos = 0;
    for (int i = 0; i < sh_nverts; i++) sh_deg[i] = 0;
    for (int i = 0; i < sh_seen; i++) begin
      sh_deg[sh_first[i]-1]++;
      sh_deg[sh_second[i]-1]++;
    end
    for (int i = 0; i < sh_nverts; i++) begin
      sh_start[i] = pos;
      pos += sh_deg[i];
      sh_deg[i] = 0;
    end
    for (int i = 0; i < sh_seen; i++) begin
      a = sh_first[i] - 1;
      b = sh_second[i] - 1;
      sh_nbr[sh_start[a] + sh_deg[a]] = b;
      sh_deg[a]++;
      sh_nbr[sh_start[b] + sh_deg[b]] = a;
      sh_deg[b]++;
    end
  endfunction

  function logic [10:0] sat11(int unsigned v);
    return v > 2047 ? 11'h7FF : v[10:0];
  endfunction

  // Advance the shadow state by one word and return its answer
  function answer_t predict_answer(word_t w);
    answer_t r;
    int unsigned c, v, s, nb, dg;
    bit digit, ok;
    r.st = ST_BYTE;
    nb = 0;
    dg = 0;
    if (w.cmd == CMD_TEXT) begin
      c = 32'(w.byt);
      digit = c >= CH_ZERO && c <= CH_NINE;
      sh_ready = 0;
      if (digit) begin
        case (sh_phase)
          PH_LEAD: sh_phase = PH_VCT;
          PH_GAP1: sh_phase = PH_ECT;
          PH_GAP2, PH_GAP4: sh_phase = PH_A;
          PH_GAP3: sh_phase = PH_B;
          default: ;
        endcase
        sh_acc = sh_acc * RADIX + (c - CH_ZERO);
        if (sh_acc > NUM_CAP) sh_acc = 32'(NUM_CAP);
      end else if (c <= CH_SPACE) begin
        file_number();
      end else begin
        sh_failed = 1;
      end
      if (w.last) begin
        ok = !sh_failed && !digit && sh_phase == PH_GAP4 && sh_seen == sh_nedges;
        if (ok) build_lists();
        sh_ready = ok;
        r.st = ok ? ST_OK : ST_BAD;
        sh_phase = PH_LEAD;
        sh_acc = 0;
        sh_seen = 0;
        sh_failed = 0;
      end
    end else begin
      v = 32'(w.vtx);
      s = 32'(w.slt);
      r.st = ST_RANGE;
      if (sh_ready && v != 0 && v <= sh_nverts) begin
        dg = sh_deg[v-1];
        if (s < dg) begin
          nb = sh_nbr[sh_start[v-1] + s] + 1;
          r.st = ST_OK;
        end
      end
    end
    r.vt = sat11(sh_nverts);
    r.et = sat11(sh_nedges);
    r.nb = nb[10:0];
    r.dg = dg[11:0];
    return r;
  endfunction

  // Take words, predict, and check strobed results against the oldest answer
  always @(posedge clk) begin
    answer_t exp_a;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else if (!rst) begin
      if (done) begin
        if (awaited_answers.size() == 0) begin
          $error("result word with no answer awaited");
          fail_count++;
        end else begin
          exp_a = awaited_answers.pop_front();
          if (status !== exp_a.st) begin
            $error("status: expected %0d, got %0d", exp_a.st, status);
            fail_count++;
          end
          if (vertex_total !== exp_a.vt) begin
            $error("vertex_total: expected %0d, got %0d", exp_a.vt, vertex_total);
            fail_count++;
          end
          if (edge_total !== exp_a.et) begin
            $error("edge_total: expected %0d, got %0d", exp_a.et, edge_total);
            fail_count++;
          end
          if (neighbor !== exp_a.nb) begin
            $error("neighbor: expected %0d, got %0d", exp_a.nb, neighbor);
            fail_count++;
          end
          if (degree !== exp_a.dg) begin
            $error("degree: expected %0d, got %0d", exp_a.dg, degree);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        awaited_answers.push_back(predict_answer(cur_word));
        words_taken <= words_taken + 1;
      end
    end
  end

  // Drive the next word once the current one is taken, with random gaps
  always @(negedge clk) begin
    if (rst || words_issued != words_taken) begin
      // hold the current word
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_words.size() == 0) begin
      start <= 1'b0;
    end else begin
      cur_word = pending_words.pop_front();
      command <= cur_word.cmd;
      text_byte <= cur_word.byt;
      last_byte <= cur_word.last;
      vertex <= cur_word.vtx;
      slot <= cur_word.slt;
      start <= 1'b1;
      words_issued <= words_issued + 1;
      if (burst_left > 0) begin
        burst_left <= burst_left - 1;
        gap_left <= 0;
      end else if ($urandom_range(0, 99) < 3) begin
        burst_left <= $urandom_range(20, 80);
        gap_left <= 0;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: gap_left <= 0;
          5, 6, 7: gap_left <= $urandom_range(1, 3);
          8: gap_left <= $urandom_range(4, 8);
          default: gap_left <= $urandom_range(10, 40);
        endcase
      end
    end
  end

  task automatic add_byte(logic [7:0] b, logic is_last = 1'b0);
    word_t w;
    w.cmd = CMD_TEXT;
    w.byt = b;
    w.last = is_last;
    w.vtx = 11'($urandom_range(0, 2047));
    w.slt = 11'($urandom_range(0, 2047));
    pending_words.push_back(w);
  endtask

  task automatic add_query(int v, int s);
    word_t w;
    w.cmd = CMD_QUERY;
    w.byt = 8'($urandom_range(0, 255));
    w.last = 1'($urandom_range(0, 1));
    w.vtx = 11'(v);
    w.slt = 11'(s);
    pending_words.push_back(w);
  endtask

  task automatic add_number(int unsigned n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_space(logic is_last = 1'b0);
    if ($urandom_range(0, 3) == 0) add_byte(8'($urandom_range(0, 32)));
    add_byte($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(0, 32)), is_last);
  endtask

  // Describe a random graph; flaw picks how the description is broken
  task automatic add_graph(int nv, int ne, int flaw);
    int pairs;
    pairs = ne;
    if (flaw == 2) pairs = ne + 1;
    if (flaw == 3 && ne > 0) pairs = ne - 1;
    if ($urandom_range(0, 3) == 0) add_space();
    add_number(flaw == 7 ? NV + $urandom_range(1, 200000) : nv);
    add_space();
    add_number(flaw == 8 ? NE + $urandom_range(1, 3000) : ne);
    for (int i = 0; i < pairs; i++) begin
      add_space();
      add_number((flaw == 1 && i == pairs - 1) ? ($urandom_range(0, 1) ? 0 : nv + 1)
                                               : $urandom_range(1, nv));
      add_space();
      add_number($urandom_range(1, nv));
    end
    case (flaw)
      4: begin
        add_byte($urandom_range(0, 1) ? 8'hFF : 8'h41);
        add_space(1'b1);
      end
      5: add_byte(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b1);
      6: begin
        add_space();
        add_number($urandom_range(1, nv));
        add_space(1'b1);
      end
      default: add_space(1'b1);
    endcase
  endtask

  initial begin
    int nv, ne, flaw;
    // directed: query before any graph, a small graph and its boundary queries
    add_query(1, 0);
    add_byte("2"); add_byte(8'h00); add_byte("1"); add_byte(8'h0A);
    add_byte("1"); add_byte(CH_SPACE); add_byte("2"); add_byte(8'h0A, 1'b1);
    add_query(1, 0);
    add_query(2, 0);
    add_query(1, 1);
    add_query(0, 0);
    add_query(2047, 2047);
    add_query(3, 0);
    // a self loop lands twice in its own list
    add_byte("1"); add_byte(" "); add_byte("1"); add_byte(" ");
    add_byte("1"); add_byte(" "); add_byte("1"); add_byte(" ", 1'b1);
    add_query(1, 1);
    add_query(1, 2047);
    // a stray top byte, then a final digit
    add_byte(8'hFF, 1'b1);
    add_byte("7", 1'b1);
    add_query(1, 0);

    // random part: mostly well-formed graphs with queries, some broken
    while (pending_words.size() < 680) begin
      nv = ($urandom_range(0, 49) == 0) ? NV : $urandom_range(1, 12);
      ne = $urandom_range(1, 8);
      flaw = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 8);
      add_graph(nv, ne, flaw);
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 7) == 0)
          add_query($urandom_range(0, 2047), $urandom_range(0, 2047));
        else
          add_query($urandom_range(0, nv + 1), $urandom_range(0, 4));
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && words_issued == words_taken &&
          awaited_answers.size() == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && awaited_answers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    sh_phase = PH_LEAD;
    sh_acc = 0;
    sh_nverts = 0;
    sh_nedges = 0;
    sh_seen = 0;
    sh_failed = 0;
    sh_ready = 0;
  end

endmodule
